// File: hdl/fbfl_pkg.sv
package fbfl_pkg;

  // pool geometry
  localparam int MAX_BLOCKS = 256;
  localparam int INDEX_W    = $clog2(MAX_BLOCKS);
  localparam int COUNT_W    = $clog2(MAX_BLOCKS + 1);
  localparam int BYTES_W    = 13;
  localparam int OFFSET_W   = 20;
  localparam int PROD_W     = INDEX_W + BYTES_W;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;

  localparam logic [COUNT_W-1:0] POOL_MAX = COUNT_W'(MAX_BLOCKS);

  // request codes
  localparam logic [1:0] REQ_ACQUIRE = 2'd0;
  localparam logic [1:0] REQ_RELEASE = 2'd1;
  localparam logic [1:0] REQ_REINIT  = 2'd2;

  // status codes
  localparam logic [1:0] STAT_OK          = 2'd0;
  localparam logic [1:0] STAT_EMPTY       = 2'd1;
  localparam logic [1:0] STAT_BAD_RELEASE = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_USE = 1'd1;

  localparam logic [BYTES_W-1:0] BLOCK_BYTES_RST   = 13'd64;
  localparam logic [COUNT_W-1:0] BLOCKS_IN_USE_RST = 9'd256;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] block_index;
  } req_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  granted_index;
    logic [19:0] byte_offset;
    logic [8:0]  free_blocks;
  } resp_item_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

endpackage

// File: hdl/fbfl_ram.sv
module fbfl_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/fbfl_ctrl.sv
module fbfl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output fbfl_pkg::ctrl_cmd_t cmd
);
  import fbfl_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy     = 1'b0;
    cmd.load = 1'b0;
    cmd.exec = 1'b0;
    unique case (state)
      S_IDLE: begin
        cmd.load = start;
      end
      S_EXEC: begin
        busy     = 1'b1;
        cmd.exec = 1'b1;
      end
      default: busy = 1'b0;
    endcase
  end

  // an accepted item is executed in the very next cycle
  a_load_then_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cmd.exec)
    else $error("accepted item not executed");

  // execution lasts exactly one cycle
  a_exec_single: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> !cmd.exec)
    else $error("exec held longer than one cycle");

endmodule

// File: hdl/fbfl_datapath.sv
module fbfl_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  fbfl_pkg::ctrl_cmd_t                 cmd,
  input  fbfl_pkg::req_item_t                 req,
  input  logic                                cfg_we,
  input  logic [fbfl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fbfl_pkg::CFG_DATA_W-1:0]     cfg_data,
  output fbfl_pkg::resp_item_t                resp,
  output logic                                done
);
  import fbfl_pkg::*;

  logic [BYTES_W-1:0]    block_bytes;
  logic [COUNT_W-1:0]    blocks_in_use;
  logic [COUNT_W-1:0]    head;
  logic [COUNT_W-1:0]    head_next;
  logic [COUNT_W-1:0]    count;
  logic [COUNT_W-1:0]    count_next;
  logic [MAX_BLOCKS-1:0] valid;
  req_item_t             req_q;

  logic [COUNT_W-1:0]    pool_n;
  logic [COUNT_W-1:0]    link_rd;
  logic [COUNT_W-1:0]    link;
  logic                  acq_fail;
  logic                  rel_fail;
  logic [1:0]            status_next;
  logic [INDEX_W-1:0]    granted_next;
  logic [PROD_W-1:0]     product;
  logic                  link_we;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      block_bytes   <= BLOCK_BYTES_RST;
      blocks_in_use <= BLOCKS_IN_USE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BLOCK_BYTES:   block_bytes   <= cfg_data[BYTES_W-1:0];
        CFG_BLOCKS_IN_USE: blocks_in_use <= cfg_data[COUNT_W-1:0];
        default:           block_bytes   <= block_bytes;
      endcase
    end
  end

  // effective pool size, capped at the array depth
  assign pool_n = (blocks_in_use > POOL_MAX) ? POOL_MAX : blocks_in_use;

  // latch the item on accept
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req;
    end
  end

  // link store: read at head on accept, written by a release
  assign link_we = cmd.exec && (req_q.req_type == REQ_RELEASE) && !rel_fail;

  fbfl_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (MAX_BLOCKS)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (req_q.block_index[INDEX_W-1:0]),
    .wdata (head),
    .re    (cmd.load),
    .raddr (head[INDEX_W-1:0]),
    .rdata (link_rd)
  );

  // an entry never written since reinit holds its index plus one
  assign link = valid[head[INDEX_W-1:0]] ? link_rd : head + COUNT_W'(1);

  assign acq_fail = (count == '0) || (head >= pool_n);
  assign rel_fail = (COUNT_W'(req_q.block_index) >= pool_n) || (count >= pool_n);

  // request execution
  always_comb begin
    head_next    = head;
    count_next   = count;
    status_next  = STAT_OK;
    granted_next = '0;
    unique case (req_q.req_type)
      REQ_ACQUIRE: begin
        if (acq_fail) begin
          status_next = STAT_EMPTY;
        end else begin
          granted_next = head[INDEX_W-1:0];
          head_next    = link;
          count_next   = count - COUNT_W'(1);
        end
      end
      REQ_RELEASE: begin
        if (rel_fail) begin
          status_next = STAT_BAD_RELEASE;
        end else begin
          head_next  = COUNT_W'(req_q.block_index);
          count_next = count + COUNT_W'(1);
        end
      end
      REQ_REINIT: begin
        head_next  = '0;
        count_next = pool_n;
      end
      default: status_next = STAT_OK;
    endcase
  end

  // offset of the granted block
  assign product = PROD_W'(granted_next) * PROD_W'(block_bytes);

  // free list state
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= BLOCKS_IN_USE_RST;
      valid <= '0;
    end else if (cmd.exec) begin
      head  <= head_next;
      count <= count_next;
      if (req_q.req_type == REQ_REINIT) begin
        valid <= '0;
      end else if (link_we) begin
        valid[req_q.block_index[INDEX_W-1:0]] <= 1'b1;
      end
    end
  end

  // result register and strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.exec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      resp.status        <= status_next;
      resp.granted_index <= granted_next;
      resp.byte_offset   <= product[OFFSET_W-1:0];
      resp.free_blocks   <= count_next;
    end
  end

  // the free count never exceeds the array depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= POOL_MAX)
    else $error("free count above pool depth");

  // a failed request reports no granted block
  a_fail_no_grant: assert property (@(posedge clk) disable iff (rst)
    done && (resp.status != STAT_OK) |-> (resp.granted_index == '0)
      && (resp.byte_offset == '0))
    else $error("failed request reports a block");

endmodule

// File: hdl/fixed_block_free_list_allocator.sv
// flow: an accepted item is latched with the link store read at the head, then
//   executed; result and done are registered; done lasts exactly one cycle
// issue: no new item is accepted while busy, since the link store read at the
//   head precedes the head update; reinit invalidates all links together
// reset: synchronous; block_bytes 64, blocks_in_use 256, full free list linked
//   in order, ready as soon as reset drops; the receiver cannot stall
module fixed_block_free_list_allocator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  fbfl_pkg::req_item_t             req,
  output fbfl_pkg::resp_item_t            resp,
  output logic                            done,
  input  logic                            cfg_we,
  input  logic [fbfl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fbfl_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fbfl_pkg::*;

  ctrl_cmd_t cmd;

  // sequencer
  fbfl_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // free list datapath
  fbfl_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .resp      (resp),
    .done      (done)
  );

endmodule
